### rtl/alkr_pkg.sv
// ----------------------------------------------------------------------------
// alkr_pkg
// Shared types and constants of the analog ladder keypad repeat unit:
// key codes, ladder voltage windows, field widths and register indexes.
// ----------------------------------------------------------------------------
package alkr_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned KEY_W    = 3;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [KEY_W-1:0] {
        KEY_RIGHT  = 3'd0,
        KEY_UP     = 3'd1,
        KEY_DOWN   = 3'd2,
        KEY_LEFT   = 3'd3,
        KEY_SELECT = 3'd4,
        KEY_NONE   = 3'd5
    } key_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_INTERVAL = 1'b0,
        REG_HOLD_TIME      = 1'b1
    } cfg_reg_t;

    // ladder voltage windows, lower bound inclusive, upper bound exclusive
    localparam logic [SAMPLE_W-1:0] OPEN_ABOVE   = 12'd4080;
    localparam logic [SAMPLE_W-1:0] RIGHT_BELOW  = 12'd40;
    localparam logic [SAMPLE_W-1:0] UP_LO        = 12'd550;
    localparam logic [SAMPLE_W-1:0] UP_HI        = 12'd620;
    localparam logic [SAMPLE_W-1:0] DOWN_LO      = 12'd1350;
    localparam logic [SAMPLE_W-1:0] DOWN_HI      = 12'd1400;
    localparam logic [SAMPLE_W-1:0] LEFT_LO      = 12'd2000;
    localparam logic [SAMPLE_W-1:0] LEFT_HI      = 12'd2100;
    localparam logic [SAMPLE_W-1:0] SELECT_LO    = 12'd2900;
    localparam logic [SAMPLE_W-1:0] SELECT_HI    = 12'd3100;

    // register reset values
    localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = 16'd100;
    localparam logic [CFG_W-1:0] HOLD_TIME_RST      = 16'd500;

    // settings handed from the register file to the key tracker
    typedef struct packed {
        logic [CFG_W-1:0] check_interval;
        logic [CFG_W-1:0] hold_time;
    } cfg_t;

endpackage

### rtl/analog_ladder_keypad_repeat_unit.sv
// ----------------------------------------------------------------------------
// analog_ladder_keypad_repeat_unit
// Resistor-ladder keypad decoder with check interval and auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction carries a millisecond time stamp (s_now_ms)
//   and a 12-bit ladder reading (s_adc_sample).
//   m_ channel: exactly one transaction per input, m_key_code 0..4 for a
//   reported key, 5 when there is no key event.
//   cfg channel: cfg_index 0 writes the check interval, 1 the repeat delay
//   (both in ms); always ready, write only while the unit is idle.
// Timing:
//   an input lands in the input register and then moves on to the result
//   register, which holds its key code and drives m_valid. One input per
//   cycle is sustained while m_ready is high; the key state is updated in the
//   same cycle that a result is loaded, so samples chain back to back.
// Reset:
//   aresetn low clears both stages, the key state (no key, times zero) and
//   sets the interval to 100 ms and the delay to 500 ms.
// Stall:
//   while m_ready is low the result holds; the input register keeps one
//   more sample, after which s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module analog_ladder_keypad_repeat_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [alkr_pkg::TIME_W-1:0]       s_now_ms,
    input  logic [alkr_pkg::SAMPLE_W-1:0]     s_adc_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [alkr_pkg::KEY_W-1:0]        m_key_code,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [alkr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [alkr_pkg::CFG_W-1:0]        cfg_wdata
);

    alkr_pkg::cfg_t                cfg;
    logic                          in_valid_reg;
    logic [alkr_pkg::TIME_W-1:0]   now_reg;
    logic [alkr_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          out_valid_reg;
    alkr_pkg::key_t                key_code_reg;
    alkr_pkg::key_t                key;
    alkr_pkg::key_t                result;
    logic                          advance;

    alkr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    alkr_classify u_classify (
        .sample (sample_reg),
        .key    (key)
    );

    alkr_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .now     (now_reg),
        .key     (key),
        .cfg     (cfg),
        .result  (result)
    );

    // flow control: a sample moves to the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg    <= s_now_ms;
            sample_reg <= s_adc_sample;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_code_reg <= result;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_key_code = key_code_reg;

endmodule

### rtl/alkr_cfg_regs.sv
// ----------------------------------------------------------------------------
// alkr_cfg_regs
// Configuration registers: check interval and repeat delay, written
// through a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module alkr_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [alkr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [alkr_pkg::CFG_W-1:0]        cfg_wdata,
    output alkr_pkg::cfg_t                    cfg
);

    logic [alkr_pkg::CFG_W-1:0] check_interval_reg;
    logic [alkr_pkg::CFG_W-1:0] hold_time_reg;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_interval_reg <= alkr_pkg::CHECK_INTERVAL_RST;
            hold_time_reg      <= alkr_pkg::HOLD_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                alkr_pkg::REG_CHECK_INTERVAL: check_interval_reg <= cfg_wdata;
                alkr_pkg::REG_HOLD_TIME:      hold_time_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.check_interval = check_interval_reg;
    assign cfg.hold_time      = hold_time_reg;

endmodule

### rtl/alkr_classify.sv
// ----------------------------------------------------------------------------
// alkr_classify
// Maps one ladder voltage reading to a key code by fixed voltage windows.
// ----------------------------------------------------------------------------
module alkr_classify (
    input  logic [alkr_pkg::SAMPLE_W-1:0] sample,
    output alkr_pkg::key_t                key
);

    // window compares, open circuit checked first
    always_comb begin
        if (sample > alkr_pkg::OPEN_ABOVE) begin
            key = alkr_pkg::KEY_NONE;
        end else if (sample < alkr_pkg::RIGHT_BELOW) begin
            key = alkr_pkg::KEY_RIGHT;
        end else if (sample >= alkr_pkg::UP_LO && sample < alkr_pkg::UP_HI) begin
            key = alkr_pkg::KEY_UP;
        end else if (sample >= alkr_pkg::DOWN_LO && sample < alkr_pkg::DOWN_HI) begin
            key = alkr_pkg::KEY_DOWN;
        end else if (sample >= alkr_pkg::LEFT_LO && sample < alkr_pkg::LEFT_HI) begin
            key = alkr_pkg::KEY_LEFT;
        end else if (sample >= alkr_pkg::SELECT_LO && sample < alkr_pkg::SELECT_HI) begin
            key = alkr_pkg::KEY_SELECT;
        end else begin
            key = alkr_pkg::KEY_NONE;
        end
    end

endmodule

### rtl/alkr_tracker.sv
// ----------------------------------------------------------------------------
// alkr_tracker
// Key state: previous key, time of last check and press start time.
// Decides per sample whether a key event is reported and updates state.
// ----------------------------------------------------------------------------
module alkr_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [alkr_pkg::TIME_W-1:0]    now,
    input  alkr_pkg::key_t                 key,
    input  alkr_pkg::cfg_t                 cfg,
    output alkr_pkg::key_t                 result
);

    alkr_pkg::key_t              prev_key_reg, prev_key_next;
    logic [alkr_pkg::TIME_W-1:0] last_check_reg, last_check_next;
    logic [alkr_pkg::TIME_W-1:0] press_start_reg, press_start_next;

    logic [alkr_pkg::TIME_W-1:0] since_check;
    logic [alkr_pkg::TIME_W-1:0] since_press;
    logic                        check_due;
    logic                        held_long;
    logic                        report;

    // elapsed times wrap modulo 2^32
    assign since_check = now - last_check_reg;
    assign since_press = now - press_start_reg;
    assign check_due = since_check >
        {{(alkr_pkg::TIME_W-alkr_pkg::CFG_W){1'b0}}, cfg.check_interval};
    assign held_long = since_press >
        {{(alkr_pkg::TIME_W-alkr_pkg::CFG_W){1'b0}}, cfg.hold_time};

    // event decision and next state
    always_comb begin
        prev_key_next    = prev_key_reg;
        last_check_next  = last_check_reg;
        press_start_next = press_start_reg;
        report           = 1'b0;
        if (check_due) begin
            if (key != prev_key_reg) begin
                prev_key_next = key;
                if (key != alkr_pkg::KEY_NONE) begin
                    press_start_next = now;
                    report           = 1'b1;
                end
            end else if (key != alkr_pkg::KEY_NONE && held_long) begin
                report = 1'b1;
            end
            if (!report) begin
                last_check_next = now;
            end
        end
    end

    assign result = report ? key : alkr_pkg::KEY_NONE;

    // state update once per sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg    <= alkr_pkg::KEY_NONE;
            last_check_reg  <= '0;
            press_start_reg <= '0;
        end else if (advance) begin
            prev_key_reg    <= prev_key_next;
            last_check_reg  <= last_check_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

### sim/analog_ladder_keypad_repeat_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// analog_ladder_keypad_repeat_unit_tb
// Self-checking bench for the ladder keypad decoder. A driver feeds time
// stamped ladder readings from a queue, a monitor takes key codes under
// random backpressure, and a local key tracker predicts every code.
// ----------------------------------------------------------------------------
module analog_ladder_keypad_repeat_unit_tb;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned N_PHASES        = 7;
    localparam int unsigned HALF_PHASE      = 65;

    typedef struct {
        logic [alkr_pkg::TIME_W-1:0]   now_ms;
        logic [alkr_pkg::SAMPLE_W-1:0] level;
    } reading_t;

    // dut ports
    logic                              aclk;
    logic                              aresetn      = 1'b0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic [alkr_pkg::TIME_W-1:0]       s_now_ms     = '0;
    logic [alkr_pkg::SAMPLE_W-1:0]     s_adc_sample = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic [alkr_pkg::KEY_W-1:0]        m_key_code;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [alkr_pkg::CFG_IDX_W-1:0]    cfg_index    = alkr_pkg::REG_CHECK_INTERVAL;
    logic [alkr_pkg::CFG_W-1:0]        cfg_wdata    = '0;

    // stimulus and expectation stores
    reading_t                          pending_readings[$];
    alkr_pkg::key_t                    expected_keys[$];
    int unsigned                       issued_count   = 0;
    int unsigned                       accepted_count = 0;
    int unsigned                       result_count   = 0;
    int unsigned                       err_count      = 0;
    int unsigned                       idle_cycles    = 0;
    logic [alkr_pkg::TIME_W-1:0]       ms_clock;

    // key tracker state and settings
    alkr_pkg::key_t                    prev_key;
    logic [alkr_pkg::TIME_W-1:0]       last_check_ms;
    logic [alkr_pkg::TIME_W-1:0]       press_start_ms;
    logic [alkr_pkg::CFG_W-1:0]        chk_interval;
    logic [alkr_pkg::CFG_W-1:0]        rpt_delay;

    // driver and monitor locals
    reading_t                          cur_reading;
    int unsigned                       src_wait;
    int unsigned                       src_calm;
    int unsigned                       snk_wait;
    int unsigned                       snk_calm;
    alkr_pkg::key_t                    want_key;

    analog_ladder_keypad_repeat_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_now_ms     (s_now_ms),
        .s_adc_sample (s_adc_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_code   (m_key_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ladder voltage to key
    function automatic alkr_pkg::key_t decode_level(
        input logic [alkr_pkg::SAMPLE_W-1:0] s);
        if (s > alkr_pkg::OPEN_ABOVE) return alkr_pkg::KEY_NONE;
        if (s < alkr_pkg::RIGHT_BELOW) return alkr_pkg::KEY_RIGHT;
        if (s >= alkr_pkg::UP_LO && s < alkr_pkg::UP_HI) return alkr_pkg::KEY_UP;
        if (s >= alkr_pkg::DOWN_LO && s < alkr_pkg::DOWN_HI) return alkr_pkg::KEY_DOWN;
        if (s >= alkr_pkg::LEFT_LO && s < alkr_pkg::LEFT_HI) return alkr_pkg::KEY_LEFT;
        if (s >= alkr_pkg::SELECT_LO && s < alkr_pkg::SELECT_HI)
            return alkr_pkg::KEY_SELECT;
        return alkr_pkg::KEY_NONE;
    endfunction

    // advance the key tracker by one reading and return the key code
    function automatic alkr_pkg::key_t track_key(
        input logic [alkr_pkg::TIME_W-1:0]   now,
        input logic [alkr_pkg::SAMPLE_W-1:0] s);
        logic [alkr_pkg::TIME_W-1:0] since_check;
        logic [alkr_pkg::TIME_W-1:0] since_press;
        alkr_pkg::key_t              k;
        logic                        report;
        since_check = now - last_check_ms;
        since_press = now - press_start_ms;
        report      = 1'b0;
        k           = decode_level(s);
        if (since_check <= {16'd0, chk_interval}) return alkr_pkg::KEY_NONE;
        if (k != prev_key) begin
            prev_key = k;
            if (k != alkr_pkg::KEY_NONE) begin
                press_start_ms = now;
                report         = 1'b1;
            end
        end else if (k != alkr_pkg::KEY_NONE && since_press > {16'd0, rpt_delay}) begin
            report = 1'b1;
        end
        if (report) return k;
        last_check_ms = now;
        return alkr_pkg::KEY_NONE;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // any reading over the full converter range
    function automatic logic [alkr_pkg::SAMPLE_W-1:0] any_level();
        int unsigned v;
        v = $urandom_range(0, 4095);
        return v[alkr_pkg::SAMPLE_W-1:0];
    endfunction

    // random reading inside the window of a key, or outside every window for no key
    function automatic logic [alkr_pkg::SAMPLE_W-1:0] level_for(input alkr_pkg::key_t k);
        int unsigned v;
        case (k)
            alkr_pkg::KEY_RIGHT:
                v = $urandom_range(0, alkr_pkg::RIGHT_BELOW - 1);
            alkr_pkg::KEY_UP:
                v = $urandom_range(alkr_pkg::UP_LO, alkr_pkg::UP_HI - 1);
            alkr_pkg::KEY_DOWN:
                v = $urandom_range(alkr_pkg::DOWN_LO, alkr_pkg::DOWN_HI - 1);
            alkr_pkg::KEY_LEFT:
                v = $urandom_range(alkr_pkg::LEFT_LO, alkr_pkg::LEFT_HI - 1);
            alkr_pkg::KEY_SELECT:
                v = $urandom_range(alkr_pkg::SELECT_LO, alkr_pkg::SELECT_HI - 1);
            default: begin
                case ($urandom_range(0, 2))
                    0:       v = $urandom_range(alkr_pkg::OPEN_ABOVE + 1, 4095);
                    1:       v = $urandom_range(alkr_pkg::RIGHT_BELOW, alkr_pkg::UP_LO - 1);
                    default: v = $urandom_range(alkr_pkg::SELECT_HI, alkr_pkg::OPEN_ABOVE);
                endcase
            end
        endcase
        return v[alkr_pkg::SAMPLE_W-1:0];
    endfunction

    // time step between readings, sometimes right on the interval bound
    function automatic logic [alkr_pkg::TIME_W-1:0] time_step(
        input int unsigned                span,
        input logic [alkr_pkg::CFG_W-1:0] iv);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return {{(alkr_pkg::TIME_W-alkr_pkg::CFG_W){1'b0}}, iv} + $urandom_range(0, 1);
        if (r == 2) return '0;
        return $urandom_range(0, span);
    endfunction

    task automatic add_reading(input logic [alkr_pkg::TIME_W-1:0]   t,
                               input logic [alkr_pkg::SAMPLE_W-1:0] s);
        reading_t r;
        r.now_ms = t;
        r.level  = s;
        pending_readings.push_back(r);
        issued_count++;
    endtask

    // key presses of random length with glitches, mixed with noise
    task automatic queue_presses(input int unsigned                n_items,
                                 input logic [alkr_pkg::CFG_W-1:0] iv,
                                 input logic [alkr_pkg::CFG_W-1:0] dl);
        int unsigned    span;
        int unsigned    held;
        int unsigned    n;
        alkr_pkg::key_t k;
        span = iv + iv / 2 + 2;
        if (dl / 6 + 2 > span) span = dl / 6 + 2;
        n = 0;
        while (n < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                held = $urandom_range(1, 6);
                repeat (held) begin
                    if ($urandom_range(0, 9) == 0) ms_clock = $urandom;
                    else ms_clock += time_step(span, iv);
                    add_reading(ms_clock, any_level());
                    n++;
                end
            end else begin
                k    = alkr_pkg::key_t'($urandom_range(0, 5));
                held = $urandom_range(1, 30);
                repeat (held) begin
                    ms_clock += time_step(span, iv);
                    if ($urandom_range(0, 9) == 0)
                        add_reading(ms_clock, any_level());
                    else
                        add_reading(ms_clock, level_for(k));
                    n++;
                end
            end
        end
    endtask

    // block until every reading is taken and every key code checked
    task automatic wait_drained();
        while (accepted_count != issued_count || expected_keys.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input alkr_pkg::cfg_reg_t         idx,
                             input logic [alkr_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // settings mirror
    always @(posedge aclk) begin
        if (!aresetn) begin
            chk_interval <= alkr_pkg::CHECK_INTERVAL_RST;
            rpt_delay    <= alkr_pkg::HOLD_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (alkr_pkg::cfg_reg_t'(cfg_index))
                alkr_pkg::REG_CHECK_INTERVAL: chk_interval <= cfg_wdata;
                alkr_pkg::REG_HOLD_TIME:      rpt_delay    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // reading driver, predicts the key code of each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            prev_key       = alkr_pkg::KEY_NONE;
            last_check_ms  = '0;
            press_start_ms = '0;
            src_wait       = 0;
            src_calm       = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_keys.push_back(track_key(s_now_ms, s_adc_sample));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_valid <= 1'b0;
                end else if (pending_readings.size() != 0) begin
                    cur_reading = pending_readings.pop_front();
                    s_valid      <= 1'b1;
                    s_now_ms     <= cur_reading.now_ms;
                    s_adc_sample <= cur_reading.level;
                    if (src_calm > 0) src_calm--;
                    else if ($urandom_range(0, 39) == 0) src_calm = $urandom_range(20, 80);
                    else src_wait = pause_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // key code monitor with random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            snk_wait = 0;
            snk_calm = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_keys.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected key code %0d, no transaction pending",
                                 m_key_code);
                end else begin
                    want_key = expected_keys.pop_front();
                    if (m_key_code !== want_key) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("key code mismatch at result %0d: expected %0d, got %0d",
                                     result_count, want_key, m_key_code);
                    end
                end
                result_count++;
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (snk_calm > 0) snk_calm--;
                else if ($urandom_range(0, 49) == 0) snk_calm = $urandom_range(20, 80);
                else if ($urandom_range(0, 2) == 0) snk_wait = pause_len();
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        logic [alkr_pkg::CFG_W-1:0]    iv;
        logic [alkr_pkg::CFG_W-1:0]    dl;
        logic [alkr_pkg::SAMPLE_W-1:0] bounds[18];
        int unsigned                   raw;
        bounds = '{alkr_pkg::RIGHT_BELOW - 12'd1, alkr_pkg::RIGHT_BELOW,
                   alkr_pkg::UP_LO - 12'd1, alkr_pkg::UP_LO,
                   alkr_pkg::UP_HI - 12'd1, alkr_pkg::UP_HI,
                   alkr_pkg::DOWN_LO - 12'd1, alkr_pkg::DOWN_LO,
                   alkr_pkg::DOWN_HI - 12'd1, alkr_pkg::DOWN_HI,
                   alkr_pkg::LEFT_LO - 12'd1, alkr_pkg::LEFT_LO,
                   alkr_pkg::LEFT_HI - 12'd1, alkr_pkg::LEFT_HI,
                   alkr_pkg::SELECT_LO - 12'd1, alkr_pkg::SELECT_LO,
                   alkr_pkg::SELECT_HI - 12'd1, alkr_pkg::SELECT_HI};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: interval not passed, new key, held key, right key repeat
        add_reading(32'd0, 12'd0);
        add_reading(32'd101, 12'd0);
        add_reading(32'd101, 12'd0);
        add_reading(32'd700, 12'd0);
        add_reading(32'd802, 12'hFFF);
        // window bounds, each reading examined
        ms_clock = 32'd802;
        foreach (bounds[i]) begin
            ms_clock += 32'd101;
            add_reading(ms_clock, bounds[i]);
        end
        // time stamp wrap while select is held
        add_reading(32'hFFFF_FFC0, 12'd3000);
        add_reading(32'h0000_0030, 12'd3000);
        add_reading(32'h0000_0300, 12'd3000);
        wait_drained();

        // random phases over several settings, extremes included
        ms_clock = $urandom;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin iv = 16'd0;     dl = 16'd0;     end
                1:       begin iv = 16'hFFFF;  dl = 16'hFFFF;  end
                2:       begin iv = 16'd0;     dl = 16'hFFFF;  end
                3:       begin iv = 16'hFFFF;  dl = 16'd0;     end
                4:       begin iv = 16'd30;    dl = 16'd200;   end
                5: begin
                    raw = $urandom_range(0, 2000);
                    iv  = raw[alkr_pkg::CFG_W-1:0];
                    raw = $urandom_range(0, 8000);
                    dl  = raw[alkr_pkg::CFG_W-1:0];
                end
                default: begin
                    iv = alkr_pkg::CHECK_INTERVAL_RST;
                    dl = alkr_pkg::HOLD_TIME_RST;
                end
            endcase
            write_reg(alkr_pkg::REG_CHECK_INTERVAL, iv);
            write_reg(alkr_pkg::REG_HOLD_TIME, dl);
            queue_presses(HALF_PHASE, iv, dl);
            // sender holds off until the pipeline is empty
            wait_drained();
            queue_presses(HALF_PHASE, iv, dl);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (err_count == 0 && expected_keys.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
